### src/kse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keystroke sequence escaper package
// Shared types, character codes and text tables for the escaper.
// ----------------------------------------------------------------------------
package kse_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int TEXT_CHARS = 12;
   localparam int TEXT_BITS  = 8 * TEXT_CHARS;
   localparam int OFF_W      = 4;

   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_AT       = 8'h40;
   localparam logic [7:0] CHAR_PERCENT  = 8'h25;
   localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE   = 8'h7D;
   localparam logic [7:0] CHAR_LPAREN   = 8'h28;
   localparam logic [7:0] CHAR_RPAREN   = 8'h29;
   localparam logic [7:0] CHAR_TILDE    = 8'h7E;
   localparam logic [7:0] CHAR_CARET    = 8'h5E;
   localparam logic [7:0] CHAR_QUOTE    = 8'h22;
   localparam logic [7:0] CHAR_APOS     = 8'h27;
   localparam logic [7:0] CHAR_BACKTICK = 8'h60;
   localparam logic [7:0] CHAR_HIGH_MIN = 8'h7F;
   localparam logic [6:0] CHAR_ZERO     = 7'h30;
   localparam logic [6:0] CHAR_CLOSE    = 7'h7D;

   localparam logic [TEXT_BITS-1:0] ALT_HEAD_TEXT   = "%({NUMPAD0} ";
   localparam logic [TEXT_BITS-1:0] DIGIT_HEAD_TEXT = "{NUMPAD     ";
   localparam logic [OFF_W-1:0]     ALT_HEAD_LAST   = 4'd10;
   localparam logic [OFF_W-1:0]     DIGIT_CHAR_OFF  = 4'd7;
   localparam logic [OFF_W-1:0]     DIGIT_LAST_OFF  = 4'd8;

   typedef enum logic [1:0] {
      KIND_PLAIN = 2'd0,
      KIND_TAG   = 2'd1,
      KIND_ALT   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      TAG_PLUS    = 3'd0,
      TAG_AT      = 3'd1,
      TAG_PERCENT = 3'd2,
      TAG_LBRACE  = 3'd3,
      TAG_RBRACE  = 3'd4,
      TAG_LPAREN  = 3'd5,
      TAG_RPAREN  = 3'd6
   } tag_type;

   typedef struct packed {
      kind_type        kind;
      tag_type         tag;
      logic [6:0]      plain_char;
      logic [2:0][3:0] digits;
      logic [1:0]      first_digit;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic busy;
      logic pop;
   } back_status_type;

   function automatic logic [TEXT_BITS-1:0] tag_text(input tag_type tag);
      logic [TEXT_BITS-1:0] text;
      unique case (tag)
         TAG_PLUS:    text = "{PLUS}      ";
         TAG_AT:      text = "{AT}        ";
         TAG_PERCENT: text = "{PERCENT}   ";
         TAG_LBRACE:  text = "{LEFTBRACE} ";
         TAG_RBRACE:  text = "{RIGHTBRACE}";
         TAG_LPAREN:  text = "{LEFTPAREN} ";
         TAG_RPAREN:  text = "{RIGHTPAREN}";
         default:     text = "{PLUS}      ";
      endcase
      return text;
   endfunction

   function automatic logic [OFF_W-1:0] tag_last(input tag_type tag);
      logic [OFF_W-1:0] last;
      unique case (tag)
         TAG_PLUS:    last = 4'd5;
         TAG_AT:      last = 4'd3;
         TAG_PERCENT: last = 4'd8;
         TAG_LBRACE:  last = 4'd10;
         TAG_RBRACE:  last = 4'd11;
         TAG_LPAREN:  last = 4'd10;
         TAG_RPAREN:  last = 4'd11;
         default:     last = 4'd5;
      endcase
      return last;
   endfunction

   function automatic logic [6:0] text_char(input logic [TEXT_BITS-1:0] text,
                                            input logic [OFF_W-1:0]     off);
      logic [TEXT_BITS-1:0] shifted;
      shifted = text >> (8 * (TEXT_CHARS - 1 - int'(off)));
      return shifted[6:0];
   endfunction

endpackage

### src/kse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaper front end
// Classifies each incoming character and splits Alt codes into digits.
// ----------------------------------------------------------------------------
module kse_front (
   input  logic [7:0]        in_char,
   output kse_pkg::item_type item
);

   logic [1:0]  hundreds;
   logic [6:0]  rest;
   logic [14:0] tens_product;
   logic [3:0]  tens;
   logic [3:0]  ones;
   logic [1:0]  digit_count;

   // Decimal digits and their count; tens digit of a value below 100 by multiplying with 205 / 2048.
   always_comb begin
      if (in_char >= 8'd200) begin
         hundreds = 2'd2;
         rest     = 7'(in_char - 8'd200);
      end else if (in_char >= 8'd100) begin
         hundreds = 2'd1;
         rest     = 7'(in_char - 8'd100);
      end else begin
         hundreds = 2'd0;
         rest     = in_char[6:0];
      end
      tens_product = 15'(rest) * 15'd205;
      tens         = tens_product[14:11];
      ones         = 4'(rest - 7'(tens) * 7'd10);
      if (in_char >= 8'd100) begin
         digit_count = 2'd3;
      end else if (in_char >= 8'd10) begin
         digit_count = 2'd2;
      end else begin
         digit_count = 2'd1;
      end
   end

   always_comb begin
      item.kind        = kse_pkg::KIND_PLAIN;
      item.tag         = kse_pkg::TAG_PLUS;
      item.plain_char  = in_char[6:0];
      item.digits      = {{2'b00, hundreds}, tens, ones};
      item.first_digit = digit_count - 2'd1;
      unique case (in_char) inside
         kse_pkg::CHAR_PLUS: begin
            item.kind = kse_pkg::KIND_TAG;
            item.tag  = kse_pkg::TAG_PLUS;
         end
         kse_pkg::CHAR_AT: begin
            item.kind = kse_pkg::KIND_TAG;
            item.tag  = kse_pkg::TAG_AT;
         end
         kse_pkg::CHAR_PERCENT: begin
            item.kind = kse_pkg::KIND_TAG;
            item.tag  = kse_pkg::TAG_PERCENT;
         end
         kse_pkg::CHAR_LBRACE: begin
            item.kind = kse_pkg::KIND_TAG;
            item.tag  = kse_pkg::TAG_LBRACE;
         end
         kse_pkg::CHAR_RBRACE: begin
            item.kind = kse_pkg::KIND_TAG;
            item.tag  = kse_pkg::TAG_RBRACE;
         end
         kse_pkg::CHAR_LPAREN: begin
            item.kind = kse_pkg::KIND_TAG;
            item.tag  = kse_pkg::TAG_LPAREN;
         end
         kse_pkg::CHAR_RPAREN: begin
            item.kind = kse_pkg::KIND_TAG;
            item.tag  = kse_pkg::TAG_RPAREN;
         end
         kse_pkg::CHAR_TILDE, kse_pkg::CHAR_CARET, kse_pkg::CHAR_QUOTE,
         kse_pkg::CHAR_APOS, kse_pkg::CHAR_BACKTICK: begin
            item.kind = kse_pkg::KIND_ALT;
         end
         default: begin
            if (in_char >= kse_pkg::CHAR_HIGH_MIN) begin
               item.kind = kse_pkg::KIND_ALT;
            end
         end
      endcase
   end

endmodule

### src/kse_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaper item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module kse_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kse_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output kse_pkg::head_type head
);

   kse_pkg::item_type                 entries_ff [kse_pkg::QUEUE_DEPTH];
   logic [kse_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [kse_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [kse_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign full       = (count_ff == kse_pkg::QUEUE_CNT_W'(kse_pkg::QUEUE_DEPTH));
   assign do_push    = push && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### src/kse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaper back end
// Walks the queue head through its escaped text, one character per beat.
// ----------------------------------------------------------------------------
module kse_back (
   input  logic                     clock,
   input  logic                     reset,
   input  kse_pkg::head_type        head,
   output kse_pkg::back_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_take,
   output logic [6:0]               rsp_char,
   output logic                     rsp_last
);

   typedef enum logic [2:0] {
      ST_TEXT  = 3'b001,
      ST_DIGIT = 3'b010,
      ST_CLOSE = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [kse_pkg::OFF_W-1:0] off_ff, off_in;
   logic [1:0]               dsel_ff, dsel_in;
   logic                     valid_ff, valid_in;
   logic [6:0]               char_ff;
   logic                     last_ff;
   logic [6:0]               char_w;
   logic                     last_w;
   logic                     advance;
   logic                     head_pop;

   assign advance       = head.valid && (!valid_ff || rsp_take);
   assign status.busy   = (state_ff != ST_TEXT) || (off_ff != '0);
   assign status.pop    = head_pop;
   assign rsp_valid     = valid_ff;
   assign rsp_char      = char_ff;
   assign rsp_last      = last_ff;
   assign valid_in      = advance || (valid_ff && !rsp_take);

   always_comb begin
      char_w   = head.item.plain_char;
      last_w   = 1'b0;
      state_in = state_ff;
      off_in   = off_ff;
      dsel_in  = dsel_ff;
      head_pop = 1'b0;
      unique case (state_ff)
         ST_TEXT: begin
            case (head.item.kind)
               kse_pkg::KIND_TAG: begin
                  char_w = kse_pkg::text_char(kse_pkg::tag_text(head.item.tag), off_ff);
                  last_w = (off_ff == kse_pkg::tag_last(head.item.tag));
               end
               kse_pkg::KIND_ALT: begin
                  char_w = kse_pkg::text_char(kse_pkg::ALT_HEAD_TEXT, off_ff);
               end
               default: begin
                  last_w = 1'b1;
               end
            endcase
            if (advance) begin
               if (last_w) begin
                  off_in   = '0;
                  head_pop = 1'b1;
               end else if (head.item.kind == kse_pkg::KIND_ALT &&
                            off_ff == kse_pkg::ALT_HEAD_LAST) begin
                  state_in = ST_DIGIT;
                  off_in   = '0;
                  dsel_in  = head.item.first_digit;
               end else begin
                  off_in = off_ff + 1'b1;
               end
            end
         end
         ST_DIGIT: begin
            if (off_ff < kse_pkg::DIGIT_CHAR_OFF) begin
               char_w = kse_pkg::text_char(kse_pkg::DIGIT_HEAD_TEXT, off_ff);
            end else if (off_ff == kse_pkg::DIGIT_CHAR_OFF) begin
               char_w = kse_pkg::CHAR_ZERO + 7'(head.item.digits[dsel_ff]);
            end else begin
               char_w = kse_pkg::CHAR_CLOSE;
            end
            if (advance) begin
               if (off_ff == kse_pkg::DIGIT_LAST_OFF) begin
                  off_in = '0;
                  if (dsel_ff == 2'd0) begin
                     state_in = ST_CLOSE;
                  end else begin
                     dsel_in = dsel_ff - 2'd1;
                  end
               end else begin
                  off_in = off_ff + 1'b1;
               end
            end
         end
         ST_CLOSE: begin
            char_w = 7'(kse_pkg::CHAR_RPAREN);
            last_w = 1'b1;
            if (advance) begin
               state_in = ST_TEXT;
               off_in   = '0;
               head_pop = 1'b1;
            end
         end
         default: begin
            state_in = ST_TEXT;
            off_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TEXT;
         off_ff   <= '0;
         dsel_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         off_ff   <= off_in;
         dsel_ff  <= dsel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         char_ff <= char_w;
         last_ff <= last_w;
      end
   end

endmodule

### src/keystroke_sequence_escaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keystroke sequence escaper
// Turns each input character into its escaped keystroke text.
//
//   Channel    Handshake            Payload
//   input      push / full          req_in_char[7:0]
//   result     empty / pop          rsp_out_char[6:0], rsp_last_in_run
//
// Each result beat carries one character; an input yields a run of 1 to 39.
// The back end emits one character per cycle while an item waits and pop takes
// each beat; a plain character is a single beat and an escaped one a full run.
// A four-entry queue lets the input side keep accepting during long runs.
// Reset is synchronous and empties the queue and the result register.
// ----------------------------------------------------------------------------
module keystroke_sequence_escaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_char,
   output logic       empty,
   input  logic       pop,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last_in_run
);

   kse_pkg::item_type        front_item;
   kse_pkg::head_type        head;
   kse_pkg::back_status_type back_status;
   logic                     rsp_valid;

   assign empty = !rsp_valid;

   kse_front u_front (
      .in_char (req_in_char),
      .item    (front_item)
   );

   kse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (full),
      .pop       (back_status.pop),
      .head      (head)
   );

   kse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (back_status),
      .rsp_valid (rsp_valid),
      .rsp_take  (pop),
      .rsp_char  (rsp_out_char),
      .rsp_last  (rsp_last_in_run)
   );

   a_pop_needs_head : assert property (@(posedge clock) disable iff (reset)
      back_status.pop |-> head.valid)
      else $error("Queue popped while empty.");

   a_busy_needs_head : assert property (@(posedge clock) disable iff (reset)
      back_status.busy |-> head.valid)
      else $error("Run in progress without a queued item.");

   a_run_continues : assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !rsp_last_in_run) |=> !empty)
      else $error("Run stopped before its last character.");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keystroke sequence escaper testbench
// Feeds characters through the push/full side and checks every escaped
// character beat from the empty/pop side against an in-bench prediction.
// A directed set covers the tags, the Alt sequences of two and three digits,
// the high bytes and the zero byte; random characters follow, with bursty
// input, a receiver that stalls in changing patterns, one long receiver
// hold-off that fills the block, and full drains between phases.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct {
      logic [6:0] ch;
      logic       last;
   } run_char_type;

   typedef enum int {
      POP_ALWAYS,
      POP_OFTEN,
      POP_RARELY,
      POP_ALTERNATE
   } pop_mode_type;

   localparam int PHASE_ITEMS = 125;
   localparam int HOLD_AFTER  = 60;
   localparam int HOLD_CYCLES = 400;
   localparam int MAX_REPORTS = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] req_in_char = 8'h00;
   logic       empty;
   logic       pop = 1'b0;
   logic [6:0] rsp_out_char;
   logic       rsp_last_in_run;

   logic [7:0]   pending_chars[$];
   run_char_type escaped_chars[$];

   int         items_accepted = 0;
   int         beats_checked = 0;
   int         mismatches = 0;
   int         plain_items = 0;
   int         tag_items = 0;
   int         alt_items = 0;

   keystroke_sequence_escaper dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_in_char     (req_in_char),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_in_run (rsp_last_in_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic expect_escape(input logic [7:0] c);
      string        run;
      string        num;
      logic         is_alt;
      byte          b;
      run_char_type rc;
      run = "";
      is_alt = 1'b0;
      case (c)
         kse_pkg::CHAR_PLUS:    run = "{PLUS}";
         kse_pkg::CHAR_AT:      run = "{AT}";
         kse_pkg::CHAR_PERCENT: run = "{PERCENT}";
         kse_pkg::CHAR_LBRACE:  run = "{LEFTBRACE}";
         kse_pkg::CHAR_RBRACE:  run = "{RIGHTBRACE}";
         kse_pkg::CHAR_LPAREN:  run = "{LEFTPAREN}";
         kse_pkg::CHAR_RPAREN:  run = "{RIGHTPAREN}";
         kse_pkg::CHAR_TILDE, kse_pkg::CHAR_CARET, kse_pkg::CHAR_QUOTE,
         kse_pkg::CHAR_APOS, kse_pkg::CHAR_BACKTICK: is_alt = 1'b1;
         default:      is_alt = (c >= kse_pkg::CHAR_HIGH_MIN);
      endcase
      if (is_alt) begin
         num = $sformatf("%0d", c);
         run = "%({NUMPAD0}";
         for (int i = 0; i < num.len(); i++) begin
            run = {run, "{NUMPAD", num.substr(i, i), "}"};
         end
         run = {run, ")"};
         alt_items++;
      end else if (run.len() != 0) begin
         tag_items++;
      end
      if (run.len() == 0) begin
         rc.ch = c[6:0];
         rc.last = 1'b1;
         escaped_chars.push_back(rc);
         plain_items++;
      end else begin
         for (int i = 0; i < run.len(); i++) begin
            b = run[i];
            rc.ch = b[6:0];
            rc.last = (i == run.len() - 1);
            escaped_chars.push_back(rc);
         end
      end
   endtask

   function automatic logic [7:0] pick_char();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: c = 8'($urandom_range(0, 255));
         4, 5: begin
            case ($urandom_range(0, 11))
               0:  c = kse_pkg::CHAR_PLUS;
               1:  c = kse_pkg::CHAR_AT;
               2:  c = kse_pkg::CHAR_PERCENT;
               3:  c = kse_pkg::CHAR_LBRACE;
               4:  c = kse_pkg::CHAR_RBRACE;
               5:  c = kse_pkg::CHAR_LPAREN;
               6:  c = kse_pkg::CHAR_RPAREN;
               7:  c = kse_pkg::CHAR_TILDE;
               8:  c = kse_pkg::CHAR_CARET;
               9:  c = kse_pkg::CHAR_QUOTE;
               10: c = kse_pkg::CHAR_APOS;
               default: c = kse_pkg::CHAR_BACKTICK;
            endcase
         end
         default: c = 8'($urandom_range(32, 126));
      endcase
      return c;
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      logic taken;
      if (reset) begin
         push <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         taken = push && !full;
         if (taken) begin
            expect_escape(req_in_char);
            items_accepted++;
         end
         if (push && !taken) begin
            push <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            push <= 1'b0;
         end else if (pending_chars.size() == 0) begin
            push <= 1'b0;
         end else begin
            req_in_char <= pending_chars.pop_front();
            push <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // Receiver: changing stall patterns plus one long hold-off.
   pop_mode_type pop_mode = POP_ALWAYS;
   int           mode_left = 0;
   int           hold_left = 0;
   logic         hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         mode_left = 0;
         hold_left = 0;
      end else begin
         if (!hold_done && items_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               pop_mode = pop_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(8, 80);
            end else begin
               mode_left--;
            end
            case (pop_mode)
               POP_ALWAYS:    pop <= 1'b1;
               POP_OFTEN:     pop <= ($urandom_range(0, 3) != 0);
               POP_RARELY:    pop <= ($urandom_range(0, 3) == 0);
               default:       pop <= !pop;
            endcase
         end
      end
   end

   // Monitor: each accepted beat is checked against the oldest expectation.
   always @(posedge clock) begin
      run_char_type want;
      if (!reset && pop && !empty) begin
         beats_checked++;
         if (escaped_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected beat char=%h last=%b", $realtime,
                        rsp_out_char, rsp_last_in_run);
         end else begin
            want = escaped_chars.pop_front();
            if (rsp_out_char !== want.ch || rsp_last_in_run !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: mismatch char exp=%h got=%h last exp=%b got=%b",
                           $realtime, want.ch, rsp_out_char, want.last,
                           rsp_last_in_run);
            end
         end
      end
   end

   task automatic drain();
      do @(negedge clock);
      while (pending_chars.size() != 0 || push || escaped_chars.size() != 0);
   endtask

   initial begin
      logic [7:0] directed[$];
      directed = {8'h00, 8'h01, 8'h41, 8'h21, 8'h7A, kse_pkg::CHAR_PLUS,
                  kse_pkg::CHAR_AT, kse_pkg::CHAR_PERCENT, kse_pkg::CHAR_LBRACE,
                  kse_pkg::CHAR_RBRACE, kse_pkg::CHAR_LPAREN, kse_pkg::CHAR_RPAREN,
                  kse_pkg::CHAR_TILDE, kse_pkg::CHAR_CARET, kse_pkg::CHAR_QUOTE,
                  kse_pkg::CHAR_APOS, kse_pkg::CHAR_BACKTICK,
                  kse_pkg::CHAR_HIGH_MIN, 8'h80, 8'hB4, 8'hFF, 8'hAA, 8'h55,
                  8'hC8};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed[i]) pending_chars.push_back(directed[i]);
      drain();
      repeat (PHASE_ITEMS) pending_chars.push_back(pick_char());
      drain();
      repeat (PHASE_ITEMS) pending_chars.push_back(pick_char());
      drain();
      repeat (50) @(negedge clock);
      $display("Escaped %0d characters (%0d plain, %0d tags, %0d Alt sequences),",
               items_accepted, plain_items, tag_items, alt_items);
      $display("checked %0d output beats, %0d mismatches.", beats_checked, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d beats still expected.", escaped_chars.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
